@@ design/afsk_pkg.sv @@
// shared types, register indexes and the tone word function for the afsk keyer
// no dependencies
package afsk_pkg;

    localparam int CntW    = 24;
    localparam int CreditW = 26;
    localparam int WordW   = 16;
    localparam int CfgAw   = 2;
    localparam int CfgDw   = 24;

    localparam logic [CfgAw-1:0] CFG_SPACE_FFSK     = 2'd0;
    localparam logic [CfgAw-1:0] CFG_BIT_TICKS      = 2'd1;
    localparam logic [CfgAw-1:0] CFG_COUNTER_RELOAD = 2'd2;

    localparam logic [CreditW-1:0] CreditMax = {CreditW{1'b1}};

    // per-beat control from the keyer to the tick clock
    typedef struct packed {
        logic step;        // a beat is processed this cycle
        logic rearm;       // first bit of a frame: restart the clock
        logic set_pending; // bit beat: a bit period starts
    } t_clk_ctl;

    // (hz*1353245 + 65536) >> 17, kept to 16 bits
    function automatic logic [WordW-1:0] f_tone_word(input int unsigned hz);
        logic [63:0] v;
        v = 64'(hz) * 64'd1353245 + 64'd65536;
        return v[17+WordW-1:17];
    endfunction

endpackage

@@ design/afsk_tick_clock.sv @@
// bit clock: accumulates wrap-aware ticks of the down-counter into a credit
// and ends the pending bit once the credit covers bit_ticks; uses afsk_pkg
module afsk_tick_clock import afsk_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_clk_ctl           i_ctl,
    input  logic [CntW-1:0]    i_count,
    input  logic [CntW-1:0]    i_bit_ticks,
    input  logic [CntW-1:0]    i_reload,
    output logic               o_done
);

    logic [CntW-1:0]    r_last_count;
    logic [CreditW-1:0] r_credit;
    logic               r_pending;

    logic [CntW:0]      wrap_sum;
    logic [CntW:0]      elapsed;
    logic [CreditW:0]   credit_sum;
    logic [CreditW-1:0] credit_fed;
    logic [CreditW-1:0] credit_base;
    logic               pending;
    logic [CreditW-1:0] n_credit;

    always_comb begin
        wrap_sum = {1'b0, r_last_count} + {1'b0, i_reload} + (CntW+1)'(1);
        if (i_count == r_last_count) begin
            elapsed = '0;
        end else if (i_count < r_last_count) begin
            elapsed = {1'b0, r_last_count - i_count};
        end else if ({1'b0, i_count} <= wrap_sum) begin
            elapsed = wrap_sum - {1'b0, i_count};
        end else begin
            // reading above last count + reload + 1: no ticks counted
            elapsed = '0;
        end
        credit_sum = {1'b0, r_credit} + (CreditW+1)'(elapsed);
        credit_fed = credit_sum[CreditW] ? CreditMax : credit_sum[CreditW-1:0];
        credit_base = i_ctl.rearm ? '0 : credit_fed;
        pending = r_pending | i_ctl.set_pending;
        o_done = pending && (credit_base >= CreditW'(i_bit_ticks));
        n_credit = o_done ? credit_base - CreditW'(i_bit_ticks) : credit_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_count <= '0;
            r_credit     <= '0;
            r_pending    <= 1'b0;
        end else if (i_ctl.step) begin
            r_last_count <= i_count;
            r_credit     <= n_credit;
            r_pending    <= pending & ~o_done;
        end
    end

endmodule

@@ design/afsk_bit_clock_tone_keyer.sv @@
// afsk tone keyer: input register, tone selection and result register
// around the tick clock; uses afsk_pkg and afsk_tick_clock
// an input beat passes the input register and then the result register
// throughput: one beat per cycle; the tick clock state is registered on each
// step so the next beat sees it at once; stalls only on output back-pressure
// reset: synchronous active low; clears the valid, frame and tick clock state;
// data regs keep; config registers return to space_ffsk=0, bit_ticks=40000, counter_reload=479999
module afsk_bit_clock_tone_keyer import afsk_pkg::*; #(
    parameter int unsigned MARK_FREQ_HZ       = 1200,
    parameter int unsigned SPACE_FREQ_HZ      = 2200,
    parameter int unsigned FFSK_SPACE_FREQ_HZ = 1800
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CfgAw-1:0]  i_cfg_addr,
    input  logic [CfgDw-1:0]  i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,  // count_value[23:0], bit_value[24], zero pad
    input  logic [1:0]        s_axis_tuser,  // func[0], first_bit[1]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,  // tone_word[15:0]
    output logic [1:0]        m_axis_tuser   // tone_write[0], bit_done[1]
);

    localparam logic [WordW-1:0] MarkWord  = f_tone_word(MARK_FREQ_HZ);
    localparam logic [WordW-1:0] SpaceWord = f_tone_word(SPACE_FREQ_HZ);
    localparam logic [WordW-1:0] FfskWord  = f_tone_word(FFSK_SPACE_FREQ_HZ);

    logic            r_space_ffsk;
    logic [CntW-1:0] r_bit_ticks;
    logic [CntW-1:0] r_reload;

    logic            r_in_valid;
    logic            r_in_func;
    logic            r_in_first;
    logic            r_in_bit;
    logic [CntW-1:0] r_in_count;

    logic            r_frame_active;
    logic            r_current_mark;

    logic             r_out_valid;
    logic             r_out_write;
    logic             r_out_done;
    logic [WordW-1:0] r_out_word;

    logic             advance;
    logic             step;
    logic             new_frame;
    logic             tone_write;
    logic [WordW-1:0] tone_word;
    logic             bit_done;
    t_clk_ctl         clk_ctl;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_ffsk <= 1'b0;
            r_bit_ticks  <= CntW'(40000);
            r_reload     <= CntW'(479999);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SPACE_FFSK:     r_space_ffsk <= i_cfg_data[0];
                CFG_BIT_TICKS:      r_bit_ticks  <= i_cfg_data;
                CFG_COUNTER_RELOAD: r_reload     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign step          = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_count <= s_axis_tdata[CntW-1:0];
            r_in_bit   <= s_axis_tdata[CntW];
            r_in_func  <= s_axis_tuser[0];
            r_in_first <= s_axis_tuser[1];
        end
    end

    always_comb begin
        // a bit without a prior frame starts one
        new_frame  = r_in_func && (r_in_first || !r_frame_active);
        tone_write = r_in_func && (new_frame || (r_in_bit != r_current_mark));
        if (!tone_write) begin
            tone_word = '0;
        end else if (r_in_bit) begin
            tone_word = MarkWord;
        end else begin
            tone_word = r_space_ffsk ? FfskWord : SpaceWord;
        end
        clk_ctl.step        = step;
        clk_ctl.rearm       = new_frame;
        clk_ctl.set_pending = r_in_func;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_active <= 1'b0;
            r_current_mark <= 1'b0;
        end else if (step && r_in_func) begin
            r_frame_active <= 1'b1;
            r_current_mark <= r_in_bit;
        end
    end

    afsk_tick_clock u_tick_clock (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (clk_ctl),
        .i_count     (r_in_count),
        .i_bit_ticks (r_bit_ticks),
        .i_reload    (r_reload),
        .o_done      (bit_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_write <= tone_write;
            r_out_word  <= tone_word;
            r_out_done  <= bit_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;
    assign m_axis_tuser  = {r_out_done, r_out_write};

endmodule
